// File: src/assert_macros.svh
// Concurrent assertion helpers for the sorted list checkers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, skipped while reset is high.
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// Same check with a message of its own.
`define ASSERT_CLK_MSG(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error(msg);

`endif

// File: src/slid_pkg.sv
package slid_pkg;

   localparam int CAPACITY  = 32;
   localparam int IDX_W     = $clog2(CAPACITY);
   localparam int CNT_W     = $clog2(CAPACITY + 1);
   localparam int VAL_W     = 32;
   localparam int CNT_OUT_W = 7;

   typedef enum logic [1:0] {
      ACT_INSERT    = 2'd0,
      ACT_DELETE    = 2'd1,
      ACT_LIST_ASC  = 2'd2,
      ACT_LIST_DESC = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_EMPTY     = 2'd3
   } status_type;

   typedef struct packed {
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      logic [VAL_W-1:0] wr_data;
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr;
   } ram_req_type;

   typedef struct packed {
      status_type                status;
      logic signed [VAL_W-1:0]   out_value;
      logic                      last;
      logic [CNT_OUT_W-1:0]      entry_count;
   } result_type;

endpackage

// File: src/slid_if.sv
interface slid_req_if;
   import slid_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [1:0]              action;
   logic signed [VAL_W-1:0] item_value;

   modport source (output valid, output action, output item_value, input ready);
   modport sink   (input valid, input action, input item_value, output ready);
endinterface

interface slid_rsp_if;
   import slid_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [1:0]              status;
   logic signed [VAL_W-1:0] out_value;
   logic                    last;
   logic [CNT_OUT_W-1:0]    entry_count;

   modport source (output valid, output status, output out_value, output last,
                   output entry_count, input ready);
   modport sink   (input valid, input status, input out_value, input last,
                   input entry_count, output ready);
endinterface

// File: src/slid_ram.sv
module slid_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 32,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // hold read data until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/slid_out.sv
module slid_out (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  slid_pkg::result_type push_data,
   output logic                 free,
   slid_rsp_if.source           rsp
);
   import slid_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   result_type data_ff;

   assign free     = !valid_ff || rsp.ready;
   assign valid_in = push || (valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         data_ff <= push_data;
      end
   end

   assign rsp.valid       = valid_ff;
   assign rsp.status      = data_ff.status;
   assign rsp.out_value   = data_ff.out_value;
   assign rsp.last        = data_ff.last;
   assign rsp.entry_count = data_ff.entry_count;

endmodule

// File: src/slid_ctrl.sv
module slid_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   slid_req_if.sink                      req,
   input  logic                          out_free,
   output logic                          out_push,
   output slid_pkg::result_type          out_data,
   output slid_pkg::ram_req_type         ram_req,
   input  logic signed [slid_pkg::VAL_W-1:0] rd_data
);
   import slid_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_ISSUE = 5'b00010,
      S_EVAL  = 5'b00100,
      S_PUT   = 5'b01000,
      S_EMIT  = 5'b10000
   } state_type;

   state_type               state_ff, state_in;
   action_type              action_ff, action_in;
   logic signed [VAL_W-1:0] value_ff, value_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [IDX_W-1:0]        addr_ff, addr_in;
   logic [IDX_W-1:0]        pos_ff, pos_in;
   logic                    found_ff, found_in;
   status_type              status_ff, status_in;

   action_type              act_req;
   logic [CNT_W-1:0]        count_last;
   logic                    at_end;
   logic                    list_last;
   logic                    hit;

   assign act_req    = action_type'(req.action);
   assign count_last = count_ff - CNT_W'(1);
   assign at_end     = (CNT_W'(addr_ff) == count_last);
   assign list_last  = (action_ff == ACT_LIST_ASC) ? at_end : (addr_ff == '0);
   assign hit        = found_ff || (rd_data == value_ff);
   assign req.ready  = (state_ff == S_IDLE);

   always_comb begin
      state_in  = state_ff;
      action_in = action_ff;
      value_in  = value_ff;
      count_in  = count_ff;
      addr_in   = addr_ff;
      pos_in    = pos_ff;
      found_in  = found_ff;
      status_in = status_ff;
      ram_req   = '0;
      out_push  = 1'b0;
      out_data.status      = ST_OK;
      out_data.out_value   = rd_data;
      out_data.last        = 1'b1;
      out_data.entry_count = CNT_OUT_W'(count_ff);

      unique case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               action_in = act_req;
               value_in  = req.item_value;
               found_in  = 1'b0;
               status_in = ST_OK;
               unique case (act_req) inside
                  ACT_INSERT: begin
                     if (count_ff == CNT_W'(CAPACITY)) begin
                        status_in = ST_FULL;
                        state_in  = S_EMIT;
                     end else if (count_ff == '0) begin
                        ram_req.wr_en   = 1'b1;
                        ram_req.wr_addr = '0;
                        ram_req.wr_data = req.item_value;
                        count_in        = CNT_W'(1);
                        state_in        = S_EMIT;
                     end else begin
                        addr_in  = IDX_W'(count_last);
                        pos_in   = IDX_W'(count_ff);
                        state_in = S_ISSUE;
                     end
                  end
                  ACT_DELETE: begin
                     if (count_ff == '0) begin
                        status_in = ST_NOT_FOUND;
                        state_in  = S_EMIT;
                     end else begin
                        addr_in  = '0;
                        state_in = S_ISSUE;
                     end
                  end
                  ACT_LIST_ASC, ACT_LIST_DESC: begin
                     if (count_ff == '0) begin
                        status_in = ST_EMPTY;
                        state_in  = S_EMIT;
                     end else begin
                        addr_in  = (act_req == ACT_LIST_ASC) ? '0 : IDX_W'(count_last);
                        state_in = S_ISSUE;
                     end
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_ISSUE: begin
            ram_req.rd_en   = 1'b1;
            ram_req.rd_addr = addr_ff;
            state_in        = S_EVAL;
         end
         S_EVAL: begin
            unique case (action_ff) inside
               ACT_INSERT: begin
                  ram_req.wr_en   = 1'b1;
                  ram_req.wr_addr = pos_ff;
                  if (rd_data >= value_ff) begin
                     // shift this entry up one place
                     ram_req.wr_data = rd_data;
                     pos_in          = addr_ff;
                     if (addr_ff == '0) begin
                        state_in = S_PUT;
                     end else begin
                        addr_in  = addr_ff - IDX_W'(1);
                        state_in = S_ISSUE;
                     end
                  end else begin
                     ram_req.wr_data = value_ff;
                     count_in        = count_ff + CNT_W'(1);
                     state_in        = S_EMIT;
                  end
               end
               ACT_DELETE: begin
                  if (found_ff) begin
                     ram_req.wr_en   = 1'b1;
                     ram_req.wr_addr = addr_ff - IDX_W'(1);
                     ram_req.wr_data = rd_data;
                  end
                  found_in = hit;
                  if (at_end) begin
                     if (hit) begin
                        count_in = count_last;
                     end else begin
                        status_in = ST_NOT_FOUND;
                     end
                     state_in = S_EMIT;
                  end else begin
                     addr_in  = addr_ff + IDX_W'(1);
                     state_in = S_ISSUE;
                  end
               end
               ACT_LIST_ASC, ACT_LIST_DESC: begin
                  if (out_free) begin
                     out_push      = 1'b1;
                     out_data.last = list_last;
                     if (list_last) begin
                        state_in = S_IDLE;
                     end else begin
                        addr_in  = (action_ff == ACT_LIST_ASC) ? addr_ff + IDX_W'(1)
                                                               : addr_ff - IDX_W'(1);
                        state_in = S_ISSUE;
                     end
                  end
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_PUT: begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = pos_ff;
            ram_req.wr_data = value_ff;
            count_in        = count_ff + CNT_W'(1);
            state_in        = S_EMIT;
         end
         S_EMIT: begin
            out_data.status    = status_ff;
            out_data.out_value = (status_ff == ST_EMPTY) ? '0 : value_ff;
            if (out_free) begin
               out_push = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff <= action_in;
      value_ff  <= value_in;
      addr_ff   <= addr_in;
      pos_ff    <= pos_in;
      status_ff <= status_in;
   end

endmodule

// File: src/sorted_list_insert_delete.sv
// Channel   Dir  Signals                                         Item
// req_bus   in   valid ready action item_value                   one request
// rsp_bus   out  valid ready status out_value last entry_count   one result
//
// Entries live in a one-port-read, one-port-write RAM with a registered read port.
// Each entry touched takes two steps (issue read, evaluate and write back):
// insert walks down from the tail, shifting each entry >= the value up one place,
// with an extra put step when the value lands at the head; delete scans every stored
// entry; list reads each entry in turn; full, empty and first inserts need no walk.
// Reset (synchronous) empties the table at once; no clearing pass.
// A stalled rsp_bus holds the result register; the sequencer waits on it.
module sorted_list_insert_delete (
   input  logic       clock,
   input  logic       reset,
   slid_req_if.sink   req_bus,
   slid_rsp_if.source rsp_bus
);
   import slid_pkg::*;

   ram_req_type             ram_req;
   logic [VAL_W-1:0]        rd_data;
   logic                    out_free;
   logic                    out_push;
   result_type              out_data;

   slid_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req      (req_bus),
      .out_free (out_free),
      .out_push (out_push),
      .out_data (out_data),
      .ram_req  (ram_req),
      .rd_data  ($signed(rd_data))
   );

   slid_ram #(
      .WIDTH (VAL_W),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_req.wr_en),
      .wr_addr (ram_req.wr_addr),
      .wr_data (ram_req.wr_data),
      .rd_en   (ram_req.rd_en),
      .rd_addr (ram_req.rd_addr),
      .rd_data (rd_data)
   );

   slid_out u_out (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_data),
      .free      (out_free),
      .rsp       (rsp_bus)
   );

endmodule

// File: src/slid_chk.sv
`include "assert_macros.svh"

module slid_chk (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_status,
   input logic [31:0] rsp_out_value,
   input logic        rsp_last,
   input logic [6:0]  rsp_entry_count
);
   import slid_pkg::*;

   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_out_value) && $stable(rsp_last) && $stable(rsp_entry_count))
   `ASSERT_CLK(a_req_one_at_a_time, clock, reset, req_valid && req_ready |=> !req_ready)
   `ASSERT_CLK_MSG(a_count_bound, clock, reset, rsp_valid |-> rsp_entry_count <= CNT_OUT_W'(CAPACITY), "entry count beyond capacity")
   `ASSERT_CLK_MSG(a_full_count, clock, reset, rsp_valid && rsp_status == ST_FULL |-> rsp_entry_count == CNT_OUT_W'(CAPACITY) && rsp_last, "full status with room left")
   `ASSERT_CLK_MSG(a_empty_result, clock, reset, rsp_valid && rsp_status == ST_EMPTY |-> rsp_entry_count == '0 && rsp_out_value == '0 && rsp_last, "malformed empty result")

endmodule

bind sorted_list_insert_delete slid_chk u_chk (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_bus.valid),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_status      (rsp_bus.status),
   .rsp_out_value   (rsp_bus.out_value),
   .rsp_last        (rsp_bus.last),
   .rsp_entry_count (rsp_bus.entry_count)
);
